// ----- sv/gha_pkg.sv -----
package gha_pkg;

    localparam int unsigned HANDLE_W = 64;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned OP_W     = 2;
    localparam int unsigned STATUS_W = 3;

    localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OP_W-1:0] OP_RESOLVE = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_REQ = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BACKING = 3'd3;
    localparam logic [STATUS_W-1:0] ST_INVALID = 3'd4;

    // One entry of the slot table
    typedef struct packed {
        logic              live;
        logic              uav;
        logic [WORD_W-1:0] gen;
    } t_slot;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic read;
        logic commit;
    } t_cmd;

endpackage

// ----- sv/gha_ctrl.sv -----
module gha_ctrl
    import gha_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    t_cmd       cmd;

    always_comb begin
        cmd.capture = (r_state == S_IDLE) && i_in_valid;
        cmd.read    = (r_state == S_READ);
        // commit only once the result register is free or being emptied
        cmd.commit  = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (cmd.capture) n_state = S_READ;
            end
            S_READ: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (cmd.commit) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    a_capture_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.capture |=> (r_state == S_READ))
        else $error("capture not followed by read");

    a_read_execs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |=> (r_state == S_EXEC))
        else $error("read not followed by execute");

    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |=> r_out_valid)
        else $error("committed result not presented");

endmodule

// ----- sv/gha_datapath.sv -----
module gha_datapath
    import gha_pkg::*;
#(
    parameter int unsigned SLOTS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  t_cmd                                i_cmd,
    input  logic [OP_W-1:0]                     i_opcode,
    input  logic [HANDLE_W-1:0]                 i_handle_in,
    input  logic [WORD_W-1:0]                   i_element_count,
    input  logic [WORD_W-1:0]                   i_element_stride,
    input  logic                                i_want_uav,
    input  logic                                i_backing_failed,
    output logic [HANDLE_W-1:0]                 o_handle_out,
    output logic [STATUS_W-1:0]                 o_status,
    output logic                                o_slot_has_uav,
    output logic [$clog2(SLOTS+1)-1:0]          o_live_count
);

    localparam int unsigned IW = $clog2(SLOTS);
    localparam int unsigned CW = $clog2(SLOTS + 1);

    // captured request
    logic [OP_W-1:0]     r_op;
    logic [HANDLE_W-1:0] r_handle;
    logic                r_req_ok;
    logic                r_uav;
    logic                r_fail;

    // table state
    t_slot               r_slot_mem [SLOTS];
    logic [IW-1:0]       r_stack_mem [SLOTS];
    t_slot               r_slot_q;
    logic [IW-1:0]       r_stack_q;
    logic [CW-1:0]       r_hw;
    logic [CW-1:0]       r_fd;
    logic [WORD_W-1:0]   r_gc;
    logic [CW-1:0]       n_hw;
    logic [CW-1:0]       n_fd;
    logic [WORD_W-1:0]   n_gc;

    // result register
    logic [HANDLE_W-1:0] r_res_handle;
    logic [STATUS_W-1:0] r_res_status;
    logic                r_res_uav;
    logic [CW-1:0]       r_res_live;

    logic [HANDLE_W-1:0] res_handle;
    logic [STATUS_W-1:0] res_status;
    logic                res_uav;
    logic [CW-1:0]       res_live;

    logic                slot_we;
    logic [IW-1:0]       slot_wa;
    t_slot               slot_wd;
    logic                stack_we;
    logic [IW-1:0]       stack_wa;
    logic [IW-1:0]       stack_wd;

    logic [CW-1:0]       live_now;
    logic [CW-1:0]       fd_dec;
    logic [CW-1:0]       fd_pop;
    logic [IW-1:0]       alloc_idx;
    logic [WORD_W-1:0]   gen_new;
    logic [WORD_W-1:0]   h_idx;
    logic [WORD_W-1:0]   h_gen;
    logic                h_ok;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op     <= i_opcode;
            r_handle <= i_handle_in;
            r_req_ok <= (i_element_count != '0) && (i_element_stride != '0);
            r_uav    <= i_want_uav;
            r_fail   <= i_backing_failed;
        end
    end

    assign fd_dec = r_fd - CW'(1);

    // registered reads: slot named by the handle, top of the free stack
    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_slot_q  <= r_slot_mem[r_handle[IW-1:0]];
            r_stack_q <= r_stack_mem[fd_dec[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && slot_we) begin
            r_slot_mem[slot_wa] <= slot_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && stack_we) begin
            r_stack_mem[stack_wa] <= stack_wd;
        end
    end

    assign live_now = r_hw - r_fd;
    assign h_idx    = r_handle[WORD_W-1:0];
    assign h_gen    = r_handle[HANDLE_W-1:WORD_W];
    assign gen_new  = (r_gc == '0) ? WORD_W'(1) : r_gc;

    // a zero generation never matches a live slot, which also covers handle 0
    assign h_ok = (h_idx < WORD_W'(r_hw)) && r_slot_q.live
               && (r_slot_q.gen == h_gen) && (h_gen != '0);

    always_comb begin
        n_hw       = r_hw;
        n_fd       = r_fd;
        n_gc       = r_gc;
        slot_we    = 1'b0;
        slot_wa    = r_handle[IW-1:0];
        slot_wd    = r_slot_q;
        stack_we   = 1'b0;
        stack_wa   = r_fd[IW-1:0];
        stack_wd   = r_handle[IW-1:0];
        res_handle = '0;
        res_status = ST_OK;
        res_uav    = 1'b0;
        alloc_idx  = r_hw[IW-1:0];
        fd_pop     = r_fd;

        unique case (r_op)
            OP_ALLOC: begin
                if (r_fd != '0) begin
                    alloc_idx = r_stack_q;
                    fd_pop    = fd_dec;
                end
                if (!r_req_ok) begin
                    res_status = ST_BAD_REQ;
                end else if (live_now == CW'(SLOTS)) begin
                    res_status = ST_FULL;
                end else begin
                    if (r_fd == '0) n_hw = r_hw + CW'(1);
                    slot_we     = 1'b1;
                    slot_wa     = alloc_idx;
                    slot_wd.uav = r_uav;
                    if (r_fail) begin
                        // hand the slot straight back with a dead generation
                        slot_wd.live = 1'b0;
                        slot_wd.gen  = '0;
                        stack_we     = 1'b1;
                        stack_wa     = fd_pop[IW-1:0];
                        stack_wd     = alloc_idx;
                        n_fd         = fd_pop + CW'(1);
                        res_status   = ST_BACKING;
                    end else begin
                        slot_wd.live = 1'b1;
                        slot_wd.gen  = gen_new;
                        n_fd         = fd_pop;
                        // skip generation zero on wrap
                        n_gc         = (r_gc == '0) ? WORD_W'(2) : r_gc + WORD_W'(1);
                        res_handle   = {gen_new, WORD_W'(alloc_idx)};
                        res_uav      = r_uav;
                    end
                end
            end
            OP_RELEASE, OP_RESOLVE: begin
                if (h_ok) begin
                    res_handle = r_handle;
                    res_uav    = r_slot_q.uav;
                    if (r_op == OP_RELEASE) begin
                        slot_we      = 1'b1;
                        slot_wd.live = 1'b0;
                        stack_we     = 1'b1;
                        n_fd         = r_fd + CW'(1);
                    end
                end else begin
                    res_status = ST_INVALID;
                end
            end
            OP_CLEAR: begin
                n_hw = '0;
                n_fd = '0;
            end
            default: begin
                res_status = ST_OK;
            end
        endcase

        res_live = (r_op == OP_CLEAR) ? live_now : (n_hw - n_fd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hw <= '0;
            r_fd <= '0;
            r_gc <= WORD_W'(1);
        end else if (i_cmd.commit) begin
            r_hw <= n_hw;
            r_fd <= n_fd;
            r_gc <= n_gc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_res_handle <= res_handle;
            r_res_status <= res_status;
            r_res_uav    <= res_uav;
            r_res_live   <= res_live;
        end
    end

    assign o_handle_out   = r_res_handle;
    assign o_status       = r_res_status;
    assign o_slot_has_uav = r_res_uav;
    assign o_live_count   = r_res_live;

    a_fd_below_hw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fd <= r_hw)
        else $error("free stack deeper than high-water mark");

    a_hw_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hw <= CW'(SLOTS))
        else $error("high-water mark beyond table");

    a_gc_nonzero_after_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && slot_we && slot_wd.live) |=> (r_gc != '0 || $past(r_gc) == '1))
        else $error("generation counter stepped to zero from a non-maximal value");

endmodule

// ----- sv/generational_handle_allocator.sv -----
// Generational handle table. Each transfer on the slave side carries one
// operation (allocate, release, resolve or clear all) and produces exactly one
// transfer on the master side. An operation moves from input transfer to result
// in order through capturing it, the registered read of the slot table and the
// free stack, and the update of the state that also loads the result
// register. The result register lets the next operation be taken while the
// previous result still waits; if it has not been taken by the commit cycle,
// the operation holds there. The slot table is never swept after reset or
// clear: only entries below the high-water mark are consulted, and each of
// those has been written since, so there is no start-up delay.
module generational_handle_allocator
    import gha_pkg::*;
#(
    parameter int unsigned SLOTS = 64
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_s_tvalid,
    output logic                                          o_s_tready,
    // handle_in, element_count, element_stride, want_uav, backing_failed
    input  logic [135:0]                                  i_s_tdata,
    // opcode
    input  logic [OP_W-1:0]                               i_s_tuser,
    output logic                                          o_m_tvalid,
    input  logic                                          i_m_tready,
    // handle_out, slot_has_uav, live_count
    output logic [((HANDLE_W+1+$clog2(SLOTS+1)+7)/8)*8-1:0] o_m_tdata,
    // status
    output logic [STATUS_W-1:0]                           o_m_tuser
);

    localparam int unsigned CW     = $clog2(SLOTS + 1);
    localparam int unsigned OUT_W  = HANDLE_W + 1 + CW;
    localparam int unsigned OUT_TW = ((OUT_W + 7) / 8) * 8;

    t_cmd                cmd;
    logic [HANDLE_W-1:0] handle_out;
    logic                slot_has_uav;
    logic [CW-1:0]       live_count;

    gha_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .o_in_ready  (o_s_tready),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .o_cmd       (cmd)
    );

    gha_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_opcode         (i_s_tuser),
        .i_handle_in      (i_s_tdata[63:0]),
        .i_element_count  (i_s_tdata[95:64]),
        .i_element_stride (i_s_tdata[127:96]),
        .i_want_uav       (i_s_tdata[128]),
        .i_backing_failed (i_s_tdata[129]),
        .o_handle_out     (handle_out),
        .o_status         (o_m_tuser),
        .o_slot_has_uav   (slot_has_uav),
        .o_live_count     (live_count)
    );

    assign o_m_tdata = OUT_TW'({live_count, slot_has_uav, handle_out});

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import gha_pkg::*;

    localparam int unsigned SLOTS     = 64;
    localparam int unsigned LIVE_W    = $clog2(SLOTS + 1);
    localparam int unsigned RESP_W    = ((HANDLE_W + 1 + LIVE_W + 7) / 8) * 8;
    localparam int unsigned N_RANDOM  = 1500;
    localparam int unsigned N_CALM    = 200;
    localparam int unsigned HOLD_LEN  = 300;
    localparam int          LIMIT     = 200000;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [HANDLE_W-1:0] handle;
        logic [WORD_W-1:0]   count;
        logic [WORD_W-1:0]   stride;
        logic                uav;
        logic                fail;
    } t_op_req;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [STATUS_W-1:0] status;
        logic                uav;
        logic [LIVE_W-1:0]   live;
    } t_op_resp;

    // typed: the expectation is written in the row, else the predictor supplies it
    typedef struct packed {
        bit       typed;
        t_op_req  req;
        t_op_resp want;
    } t_op_row;

    typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED, MODE_NOISE} t_traffic_mode;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [135:0]        s_tdata  = '0;
    logic [OP_W-1:0]     s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [RESP_W-1:0]   m_tdata;
    logic [STATUS_W-1:0] m_tuser;

    // predicted handle table
    bit                  live_tbl [SLOTS];
    bit [WORD_W-1:0]     gen_tbl  [SLOTS];
    bit                  uav_tbl  [SLOTS];
    int unsigned         free_stk [SLOTS];
    int unsigned         free_cnt = 0;
    int unsigned         high_mark = 0;
    bit [WORD_W-1:0]     gen_ctr  = 1;

    t_op_resp            pending_results [$];
    t_op_row             directed_ops [24];

    int                  mismatches   = 0;
    int                  results_seen = 0;
    int                  ops_sent     = 0;
    int                  status_seen [5];
    int                  cycles       = 0;
    int unsigned         stall_left   = 0;
    int unsigned         hold_left    = 0;
    bit                  hold_done    = 1'b0;
    bit                  calm         = 1'b0;

    always #5 clk = ~clk;

    generational_handle_allocator #(
        .SLOTS(SLOTS)
    ) DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    function automatic int unsigned live_slots_now();
        return (high_mark >= free_cnt) ? high_mark - free_cnt : 0;
    endfunction

    // Apply one operation to the predicted table and return its result
    function automatic t_op_resp handle_table_step(t_op_req rq);
        t_op_resp        r;
        int unsigned     slot;
        bit [WORD_W-1:0] g;
        bit [WORD_W-1:0] idx;
        bit [WORD_W-1:0] hgen;
        r    = '0;
        slot = 0;
        case (rq.op)
            OP_ALLOC: begin
                if (rq.count == 0 || rq.stride == 0) begin
                    r.status = ST_BAD_REQ;
                end else if (live_slots_now() >= SLOTS) begin
                    r.status = ST_FULL;
                end else begin
                    if (free_cnt > 0) begin
                        free_cnt--;
                        slot = free_stk[free_cnt];
                    end else begin
                        slot = high_mark;
                        high_mark++;
                    end
                    if (slot >= SLOTS) begin
                        r.status = ST_FULL;
                    end else begin
                        uav_tbl[slot] = rq.uav;
                        if (rq.fail) begin
                            gen_tbl[slot] = '0;
                            if (free_cnt < SLOTS) begin
                                free_stk[free_cnt] = slot;
                                free_cnt++;
                            end
                            r.status = ST_BACKING;
                        end else begin
                            // skip generation 0 on wrap
                            g = gen_ctr;
                            gen_ctr++;
                            if (g == 0) begin
                                g = gen_ctr;
                                gen_ctr++;
                            end
                            gen_tbl[slot]  = g;
                            live_tbl[slot] = 1'b1;
                            r.handle = {g, 32'(slot)};
                            r.uav    = rq.uav;
                        end
                    end
                end
                r.live = LIVE_W'(live_slots_now());
            end
            OP_RELEASE, OP_RESOLVE: begin
                idx  = rq.handle[31:0];
                hgen = rq.handle[63:32];
                if (rq.handle != 0 && idx < high_mark && idx < SLOTS && live_tbl[idx]
                        && gen_tbl[idx] == hgen && hgen != 0) begin
                    r.handle = rq.handle;
                    r.uav    = uav_tbl[idx];
                    if (rq.op == OP_RELEASE) begin
                        live_tbl[idx] = 1'b0;
                        if (free_cnt < SLOTS) begin
                            free_stk[free_cnt] = idx;
                            free_cnt++;
                        end
                    end
                end else begin
                    r.status = ST_INVALID;
                end
                r.live = LIVE_W'(live_slots_now());
            end
            default: begin
                r.live = LIVE_W'(live_slots_now());
                for (int k = 0; k < SLOTS; k++) live_tbl[k] = 1'b0;
                high_mark = 0;
                free_cnt  = 0;
            end
        endcase
        return r;
    endfunction

    // Handle for release or resolve: mostly a live one when asked, else a broken one
    function automatic logic [HANDLE_W-1:0] pick_handle(int unsigned live_pct);
        int unsigned start;
        int unsigned j;
        int unsigned p;
        if ($urandom_range(0, 99) < live_pct) begin
            start = $urandom_range(0, SLOTS - 1);
            for (int k = 0; k < SLOTS; k++) begin
                j = (start + k) % SLOTS;
                if (live_tbl[j]) return {gen_tbl[j], 32'(j)};
            end
        end
        p = $urandom_range(0, 3);
        j = $urandom_range(0, SLOTS - 1);
        case (p)
            0:       return {gen_tbl[j], 32'(j)};
            1:       return {gen_tbl[j] - 32'($urandom_range(1, 3)), 32'(j)};
            2:       return {gen_tbl[j], 32'($urandom_range(SLOTS, 32'hFFFF_FFFF))};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] alloc_dim();
        int unsigned p;
        p = $urandom_range(0, 19);
        if (p == 0) return '0;
        if (p == 1) return '1;
        if (p < 5)  return 32'($urandom_range(1, 16));
        return $urandom;
    endfunction

    function automatic t_op_req make_request(t_traffic_mode mode);
        t_op_req     rq;
        int unsigned p;
        rq.handle = {$urandom, $urandom};
        rq.count  = alloc_dim();
        rq.stride = alloc_dim();
        rq.uav    = 1'($urandom_range(0, 1));
        rq.fail   = ($urandom_range(0, 9) == 0);
        p = $urandom_range(0, 99);
        case (mode)
            MODE_FILL: begin
                if (p < 85)       rq.op = OP_ALLOC;
                else if (p < 95)  rq.op = OP_RESOLVE;
                else              rq.op = OP_RELEASE;
                if (rq.op != OP_ALLOC) rq.handle = pick_handle(85);
            end
            MODE_DRAIN: begin
                if (p < 60)       rq.op = OP_RELEASE;
                else if (p < 80)  rq.op = OP_RESOLVE;
                else              rq.op = OP_ALLOC;
                if (rq.op != OP_ALLOC) rq.handle = pick_handle(80);
            end
            MODE_MIXED: begin
                if (p < 2)        rq.op = OP_CLEAR;
                else if (p < 38)  rq.op = OP_ALLOC;
                else if (p < 65)  rq.op = OP_RELEASE;
                else              rq.op = OP_RESOLVE;
                if (rq.op == OP_RELEASE || rq.op == OP_RESOLVE) rq.handle = pick_handle(60);
            end
            default: begin
                rq.op    = OP_W'($urandom_range(0, 3));
                rq.count = $urandom;
                rq.stride = $urandom;
            end
        endcase
        return rq;
    endfunction

    task automatic offer(input t_op_req rq, input bit typed, input t_op_resp want);
        t_op_resp predicted;
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        s_tdata  <= {6'b0, rq.fail, rq.uav, rq.stride, rq.count, rq.handle};
        s_tuser  <= rq.op;
        s_tvalid <= 1'b1;
        do @(posedge clk); while (s_tready !== 1'b1);
        predicted = handle_table_step(rq);
        pending_results.insert(pending_results.size(), typed ? want : predicted);
        ops_sent++;
    endtask

    task automatic check_result(input t_op_resp got);
        t_op_resp want;
        results_seen++;
        if (got.status <= ST_INVALID) status_seen[got.status]++;
        if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("tb: result with nothing expected: handle %h status %0d uav %0d live %0d",
                         got.handle, got.status, got.uav, got.live);
        end else begin
            want = pending_results.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"tb: mismatch at result %0d: expected handle %h status %0d ",
                              "uav %0d live %0d, got handle %h status %0d uav %0d live %0d"},
                             results_seen, want.handle, want.status, want.uav, want.live,
                             got.handle, got.status, got.uav, got.live);
            end
        end
    endtask

    // Result side: check transfers, then choose next ready
    always @(posedge clk) begin
        if (rst_n && m_tvalid === 1'b1 && m_tready)
            check_result({m_tdata[63:0], m_tuser, m_tdata[64], m_tdata[64+LIVE_W:65]});
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (!hold_done && results_seen >= 500) begin
            // long hold-off so the block fills up and stalls the sender
            hold_done <= 1'b1;
            hold_left <= HOLD_LEN - 1;
            m_tready  <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 6);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        t_traffic_mode mode;
        int unsigned   burst_left;
        int unsigned   p;
        mode       = MODE_FILL;
        burst_left = 0;
        for (int k = 0; k < 5; k++) status_seen[k] = 0;
        for (int k = 0; k < SLOTS; k++) begin
            live_tbl[k] = 1'b0;
            gen_tbl[k]  = '0;
            uav_tbl[k]  = 1'b0;
            free_stk[k] = 0;
        end

        directed_ops = '{
            '{1'b1, '{OP_RESOLVE, 64'h0, 32'd0, 32'd0, 1'b0, 1'b0},
                    '{64'h0, ST_INVALID, 1'b0, 7'd0}},
            '{1'b1, '{OP_ALLOC, 64'h0, 32'd0, 32'd5, 1'b0, 1'b0},
                    '{64'h0, ST_BAD_REQ, 1'b0, 7'd0}},
            '{1'b1, '{OP_ALLOC, 64'h0, 32'd7, 32'd0, 1'b1, 1'b0},
                    '{64'h0, ST_BAD_REQ, 1'b0, 7'd0}},
            '{1'b1, '{OP_ALLOC, 64'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0},
                    '{64'h0000_0001_0000_0000, ST_OK, 1'b1, 7'd1}},
            // backing failure: slot 1 goes straight back to the free stack
            '{1'b1, '{OP_ALLOC, 64'h0, 32'd1, 32'd1, 1'b1, 1'b1},
                    '{64'h0, ST_BACKING, 1'b0, 7'd1}},
            '{1'b1, '{OP_ALLOC, 64'h0, 32'd1, 32'd1, 1'b0, 1'b0},
                    '{64'h0000_0002_0000_0001, ST_OK, 1'b0, 7'd2}},
            '{1'b1, '{OP_RESOLVE, 64'h0000_0001_0000_0000, 32'd0, 32'd0, 1'b0, 1'b0},
                    '{64'h0000_0001_0000_0000, ST_OK, 1'b1, 7'd2}},
            '{1'b1, '{OP_RESOLVE, 64'h0000_0002_0000_0000, 32'd0, 32'd0, 1'b0, 1'b0},
                    '{64'h0, ST_INVALID, 1'b0, 7'd2}},
            '{1'b1, '{OP_RESOLVE, 64'h0000_0001_0000_0005, 32'd0, 32'd0, 1'b0, 1'b0},
                    '{64'h0, ST_INVALID, 1'b0, 7'd2}},
            '{1'b1, '{OP_RELEASE, 64'h0000_0001_FFFF_FFFF, 32'd0, 32'd0, 1'b0, 1'b0},
                    '{64'h0, ST_INVALID, 1'b0, 7'd2}},
            '{1'b1, '{OP_RELEASE, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 32'd0, 1'b1, 1'b1},
                    '{64'h0, ST_INVALID, 1'b0, 7'd2}},
            '{1'b1, '{OP_RELEASE, 64'h0000_0002_0000_0001, 32'd0, 32'd0, 1'b0, 1'b0},
                    '{64'h0000_0002_0000_0001, ST_OK, 1'b0, 7'd1}},
            '{1'b1, '{OP_RELEASE, 64'h0000_0002_0000_0001, 32'd0, 32'd0, 1'b0, 1'b0},
                    '{64'h0, ST_INVALID, 1'b0, 7'd1}},
            '{1'b1, '{OP_ALLOC, 64'h0, 32'd3, 32'd4, 1'b1, 1'b0},
                    '{64'h0000_0003_0000_0001, ST_OK, 1'b1, 7'd2}},
            // stale handle to a reused slot
            '{1'b1, '{OP_RESOLVE, 64'h0000_0002_0000_0001, 32'd0, 32'd0, 1'b0, 1'b0},
                    '{64'h0, ST_INVALID, 1'b0, 7'd2}},
            '{1'b0, '{OP_ALLOC, 64'h0, 32'h8000_0000, 32'd1, 1'b0, 1'b0},
                    '{64'h0, ST_OK, 1'b0, 7'd0}},
            '{1'b0, '{OP_RESOLVE, 64'h0000_0004_0000_0002, 32'd0, 32'd0, 1'b0, 1'b0},
                    '{64'h0, ST_OK, 1'b0, 7'd0}},
            '{1'b1, '{OP_CLEAR, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      1'b1, 1'b1},
                    '{64'h0, ST_OK, 1'b0, 7'd3}},
            '{1'b1, '{OP_RESOLVE, 64'h0000_0001_0000_0000, 32'd0, 32'd0, 1'b0, 1'b0},
                    '{64'h0, ST_INVALID, 1'b0, 7'd0}},
            '{1'b1, '{OP_RELEASE, 64'h0000_0004_0000_0002, 32'd0, 32'd0, 1'b0, 1'b0},
                    '{64'h0, ST_INVALID, 1'b0, 7'd0}},
            '{1'b1, '{OP_ALLOC, 64'h0, 32'd1, 32'd1, 1'b0, 1'b0},
                    '{64'h0000_0005_0000_0000, ST_OK, 1'b0, 7'd1}},
            '{1'b0, '{OP_ALLOC, 64'h0, 32'd2, 32'd2, 1'b1, 1'b1},
                    '{64'h0, ST_OK, 1'b0, 7'd0}},
            // generation 0 left by the backing failure never matches
            '{1'b0, '{OP_RESOLVE, 64'h0000_0000_0000_0001, 32'd0, 32'd0, 1'b0, 1'b0},
                    '{64'h0, ST_OK, 1'b0, 7'd0}},
            '{1'b1, '{OP_CLEAR, 64'h0, 32'd0, 32'd0, 1'b0, 1'b0},
                    '{64'h0, ST_OK, 1'b0, 7'd1}}
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_ops[i])
            offer(directed_ops[i].req, directed_ops[i].typed, directed_ops[i].want);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (burst_left == 0) begin
                p = $urandom_range(0, 99);
                if (p < 35) begin
                    mode       = MODE_FILL;
                    burst_left = $urandom_range(40, 120);
                end else if (p < 60) begin
                    mode       = MODE_DRAIN;
                    burst_left = $urandom_range(10, 60);
                end else if (p < 90) begin
                    mode       = MODE_MIXED;
                    burst_left = $urandom_range(10, 60);
                end else begin
                    mode       = MODE_NOISE;
                    burst_left = $urandom_range(5, 20);
                end
            end
            burst_left--;
            if (n == N_RANDOM - N_CALM) calm <= 1'b1;
            if (n == 750) begin
                // hold the sender until the block has drained
                s_tvalid <= 1'b0;
                do @(posedge clk); while (pending_results.size() != 0);
            end
            offer(make_request(mode), 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        $display("run: %0d operations sent, %0d results checked, %0d mismatches",
                 ops_sent, results_seen, mismatches);
        $display("run: status ok %0d, bad request %0d, full %0d, backing %0d, invalid %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4]);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
